FILE: rtl/ptsp_pkg.sv
// Shared types and constants for the point to segment projection pipeline.
`default_nettype none
package ptsp_pkg;

  localparam int LAT_W = 30;
  localparam int LON_W = 31;
  localparam int TOL_W = 23;
  localparam int DLAT_W = LAT_W + 1;
  localparam int DLON_W = LON_W + 1;
  localparam int LATB_W = LAT_W + 2;
  localparam int LONB_W = LON_W + 2;
  localparam int NUM_W = 63;
  localparam int DEN_W = 63;
  localparam int FACTOR_FRAC_BITS = 32;
  localparam int QUO_W = NUM_W + FACTOR_FRAC_BITS;
  localparam int LIMB_W = 32;
  localparam int TOP_W = QUO_W - 2 * LIMB_W;
  localparam int PROD_W = QUO_W + LIMB_W;
  localparam int WIDE_W = 64;
  localparam int OUT_W = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4194);

  typedef struct packed {
    logic signed [LAT_W-1:0]  plat;
    logic signed [LON_W-1:0]  plon;
    logic [DLAT_W-1:0]        mdlat;
    logic                     sdlat;
    logic [DLON_W-1:0]        mdlon;
    logic                     sdlon;
    logic                     kneg;
    logic                     degen;
    logic signed [LATB_W-1:0] lat_lo;
    logic signed [LATB_W-1:0] lat_hi;
    logic signed [LONB_W-1:0] lon_lo;
    logic signed [LONB_W-1:0] lon_hi;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] nq;
    side_t            side;
  } div_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] foot_lat;
    logic signed [OUT_W-1:0] foot_lon;
    logic                    on_segment;
    logic                    degenerate;
    logic                    clipped;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/point_to_segment_projection.sv
// Top level: perpendicular foot of a point on the line through two nodes.
// Pipeline: front stages, restoring divide stages, back stages and an output register.
// Throughput: one request per cycle while the skid entry is empty; the 95-stage restoring divider sets the depth.
// Output stalls freeze the whole pipeline while the skid entry is full.
// Reset (rst, synchronous) clears all valid bits and sets tolerance to 4194.
`default_nettype none
module point_to_segment_projection (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ptsp_pkg::TOL_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ptsp_pkg::LAT_W-1:0] point_lat,
  input  logic signed [ptsp_pkg::LON_W-1:0] point_lon,
  input  logic signed [ptsp_pkg::LAT_W-1:0] first_lat,
  input  logic signed [ptsp_pkg::LON_W-1:0] first_lon,
  input  logic signed [ptsp_pkg::LAT_W-1:0] second_lat,
  input  logic signed [ptsp_pkg::LON_W-1:0] second_lon,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ptsp_pkg::OUT_W-1:0] foot_lat,
  output logic signed [ptsp_pkg::OUT_W-1:0] foot_lon,
  output logic                              on_segment,
  output logic                              degenerate,
  output logic                              clipped
);
  import ptsp_pkg::*;

  logic [TOL_W-1:0] tolerance;
  logic             en;
  logic             dv [QUO_W+1];
  div_t             di [QUO_W+1];
  logic             res_valid;
  res_t             res_item;
  res_t             out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  assign in_ready = en;

  ptsp_front u_front (
    .clk, .rst, .en,
    .in_valid, .point_lat, .point_lon, .first_lat, .first_lon,
    .second_lat, .second_lon, .tolerance,
    .out_valid (dv[0]),
    .out_item  (di[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    ptsp_div_stage u_stage (
      .clk, .rst, .en,
      .in_valid  (dv[i]),
      .in_item   (di[i]),
      .out_valid (dv[i+1]),
      .out_item  (di[i+1])
    );
  end

  ptsp_back u_back (
    .clk, .rst, .en,
    .in_valid  (dv[QUO_W]),
    .in_item   (di[QUO_W]),
    .out_valid (res_valid),
    .out_item  (res_item)
  );

  ptsp_out u_out (
    .clk, .rst,
    .in_valid  (res_valid && en),
    .in_item   (res_item),
    .advance   (en),
    .out_valid,
    .out_ready,
    .out_item
  );

  assign foot_lat   = out_item.foot_lat;
  assign foot_lon   = out_item.foot_lon;
  assign on_segment = out_item.on_segment;
  assign degenerate = out_item.degenerate;
  assign clipped    = out_item.clipped;

endmodule
`default_nettype wire

FILE: rtl/ptsp_front.sv
// Front stages: differences, bounds, products, cross product and squared length.
`default_nettype none
module ptsp_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [ptsp_pkg::LAT_W-1:0] point_lat,
  input  logic signed [ptsp_pkg::LON_W-1:0] point_lon,
  input  logic signed [ptsp_pkg::LAT_W-1:0] first_lat,
  input  logic signed [ptsp_pkg::LON_W-1:0] first_lon,
  input  logic signed [ptsp_pkg::LAT_W-1:0] second_lat,
  input  logic signed [ptsp_pkg::LON_W-1:0] second_lon,
  input  logic [ptsp_pkg::TOL_W-1:0]        tolerance,
  output logic                              out_valid,
  output ptsp_pkg::div_t                    out_item
);
  import ptsp_pkg::*;

  logic signed [DLAT_W-1:0] dlat_c, dplat_c;
  logic signed [DLON_W-1:0] dlon_c, dplon_c;
  logic signed [LATB_W-1:0] lat_min_c, lat_max_c;
  logic signed [LONB_W-1:0] lon_min_c, lon_max_c;
  logic signed [TOL_W:0]    tol_s;

  logic                     v0;
  logic signed [LAT_W-1:0]  plat0;
  logic signed [LON_W-1:0]  plon0;
  logic signed [DLAT_W-1:0] dlat0, dplat0;
  logic signed [DLON_W-1:0] dlon0, dplon0;
  logic signed [LATB_W-1:0] lat_lo0, lat_hi0;
  logic signed [LONB_W-1:0] lon_lo0, lon_hi0;
  logic                     degen0;

  logic signed [WIDE_W-1:0] prod_a_c, prod_b_c, sqa_c, sqb_c;
  logic                     v1;
  logic signed [WIDE_W-1:0] prod_a1, prod_b1, sqa1, sqb1;
  side_t                    side1;

  logic                     v2;
  logic signed [WIDE_W-1:0] num2;
  logic [DEN_W-1:0]         den2;
  side_t                    side2;

  logic [WIDE_W-1:0]        nabs_c;
  side_t                    side3_c;

  always_comb begin
    dlat_c  = DLAT_W'(second_lat) - DLAT_W'(first_lat);
    dlon_c  = DLON_W'(second_lon) - DLON_W'(first_lon);
    dplat_c = DLAT_W'(point_lat) - DLAT_W'(first_lat);
    dplon_c = DLON_W'(point_lon) - DLON_W'(first_lon);
    tol_s   = $signed({1'b0, tolerance});
    lat_min_c = (first_lat < second_lat) ? LATB_W'(first_lat) : LATB_W'(second_lat);
    lat_max_c = (first_lat < second_lat) ? LATB_W'(second_lat) : LATB_W'(first_lat);
    lon_min_c = (first_lon < second_lon) ? LONB_W'(first_lon) : LONB_W'(second_lon);
    lon_max_c = (first_lon < second_lon) ? LONB_W'(second_lon) : LONB_W'(first_lon);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      plat0   <= point_lat;
      plon0   <= point_lon;
      dlat0   <= dlat_c;
      dlon0   <= dlon_c;
      dplat0  <= dplat_c;
      dplon0  <= dplon_c;
      lat_lo0 <= lat_min_c - LATB_W'(tol_s);
      lat_hi0 <= lat_max_c + LATB_W'(tol_s);
      lon_lo0 <= lon_min_c - LONB_W'(tol_s);
      lon_hi0 <= lon_max_c + LONB_W'(tol_s);
      degen0  <= (dlat_c == '0) && (dlon_c == '0);
    end
  end

  always_comb begin
    prod_a_c = WIDE_W'(dlat0) * WIDE_W'(dplon0);
    prod_b_c = WIDE_W'(dlon0) * WIDE_W'(dplat0);
    sqa_c    = WIDE_W'(dlat0) * WIDE_W'(dlat0);
    sqb_c    = WIDE_W'(dlon0) * WIDE_W'(dlon0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      prod_a1      <= prod_a_c;
      prod_b1      <= prod_b_c;
      sqa1         <= sqa_c;
      sqb1         <= sqb_c;
      side1.plat   <= plat0;
      side1.plon   <= plon0;
      side1.mdlat  <= dlat0[DLAT_W-1] ? DLAT_W'(-dlat0) : DLAT_W'(dlat0);
      side1.sdlat  <= dlat0[DLAT_W-1];
      side1.mdlon  <= dlon0[DLON_W-1] ? DLON_W'(-dlon0) : DLON_W'(dlon0);
      side1.sdlon  <= dlon0[DLON_W-1];
      side1.kneg   <= 1'b0;
      side1.degen  <= degen0;
      side1.lat_lo <= lat_lo0;
      side1.lat_hi <= lat_hi0;
      side1.lon_lo <= lon_lo0;
      side1.lon_hi <= lon_hi0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      num2  <= prod_a1 - prod_b1;
      den2  <= DEN_W'(sqa1 + sqb1);
      side2 <= side1;
    end
  end

  always_comb begin
    nabs_c       = num2[WIDE_W-1] ? WIDE_W'(-num2) : WIDE_W'(num2);
    side3_c      = side2;
    side3_c.kneg = num2[WIDE_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      out_item.den  <= den2;
      out_item.rem  <= '0;
      out_item.nq   <= {nabs_c[NUM_W-1:0], {FACTOR_FRAC_BITS{1'b0}}};
      out_item.side <= side3_c;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ptsp_div_stage.sv
// One restoring division step: one quotient bit per stage.
`default_nettype none
module ptsp_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  ptsp_pkg::div_t in_item,
  output logic           out_valid,
  output ptsp_pkg::div_t out_item
);
  import ptsp_pkg::*;

  logic [DEN_W:0] r2;
  logic [DEN_W:0] diff;
  logic           ge;

  always_comb begin
    r2   = {in_item.rem, in_item.nq[QUO_W-1]};
    diff = r2 - {1'b0, in_item.den};
    ge   = (r2 >= {1'b0, in_item.den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_item.den  <= in_item.den;
      out_item.rem  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      out_item.nq   <= {in_item.nq[QUO_W-2:0], ge};
      out_item.side <= in_item.side;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ptsp_back.sv
// Back stages: factor times deltas, offset clamp, foot, bounds test, saturation and degenerate zeroing.
`default_nettype none
module ptsp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  ptsp_pkg::div_t in_item,
  output logic           out_valid,
  output ptsp_pkg::res_t out_item
);
  import ptsp_pkg::*;

  localparam int VW = PROD_W - FACTOR_FRAC_BITS;
  localparam int MAGW = WIDE_W - 1;

  logic                       v0;
  logic [2*LIMB_W-1:0]        pla0, pla1, pla2, plo0, plo1, plo2;
  side_t                      side0;

  logic [PROD_W-1:0]          sum_lat_c, sum_lon_c;
  logic                       v1;
  logic [VW-1:0]              vlat1, vlon1;
  side_t                      side1;

  logic [MAGW-1:0]            mlat_c, mlon_c;
  logic                       v2;
  logic signed [WIDE_W-1:0]   off_lat2, off_lon2;
  side_t                      side2;

  logic                       v3;
  logic signed [WIDE_W-1:0]   flat3, flon3;
  side_t                      side3;

  logic                       on_c, clat_c, clon_c;
  logic signed [OUT_W-1:0]    slat_c, slon_c;
  localparam logic signed [WIDE_W-1:0] SMAX = WIDE_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] SMIN = -SMAX - WIDE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      pla0  <= (2*LIMB_W)'(in_item.nq[LIMB_W-1:0]) * (2*LIMB_W)'(in_item.side.mdlon);
      pla1  <= (2*LIMB_W)'(in_item.nq[2*LIMB_W-1:LIMB_W]) * (2*LIMB_W)'(in_item.side.mdlon);
      pla2  <= (2*LIMB_W)'(in_item.nq[QUO_W-1:2*LIMB_W]) * (2*LIMB_W)'(in_item.side.mdlon);
      plo0  <= (2*LIMB_W)'(in_item.nq[LIMB_W-1:0]) * (2*LIMB_W)'(in_item.side.mdlat);
      plo1  <= (2*LIMB_W)'(in_item.nq[2*LIMB_W-1:LIMB_W]) * (2*LIMB_W)'(in_item.side.mdlat);
      plo2  <= (2*LIMB_W)'(in_item.nq[QUO_W-1:2*LIMB_W]) * (2*LIMB_W)'(in_item.side.mdlat);
      side0 <= in_item.side;
    end
  end

  always_comb begin
    sum_lat_c = PROD_W'(pla0) + (PROD_W'(pla1) << LIMB_W) + (PROD_W'(pla2) << (2*LIMB_W));
    sum_lon_c = PROD_W'(plo0) + (PROD_W'(plo1) << LIMB_W) + (PROD_W'(plo2) << (2*LIMB_W));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      vlat1 <= sum_lat_c[PROD_W-1:FACTOR_FRAC_BITS];
      vlon1 <= sum_lon_c[PROD_W-1:FACTOR_FRAC_BITS];
      side1 <= side0;
    end
  end

  // offset magnitude clamps at 2^62
  always_comb begin
    if ((|vlat1[VW-1:MAGW]) || (vlat1[MAGW-1] && (|vlat1[MAGW-2:0]))) begin
      mlat_c = MAGW'(1) << (MAGW - 1);
    end else begin
      mlat_c = vlat1[MAGW-1:0];
    end
    if ((|vlon1[VW-1:MAGW]) || (vlon1[MAGW-1] && (|vlon1[MAGW-2:0]))) begin
      mlon_c = MAGW'(1) << (MAGW - 1);
    end else begin
      mlon_c = vlon1[MAGW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      off_lat2 <= (side1.kneg ^ side1.sdlon) ? -$signed({1'b0, mlat_c}) : $signed({1'b0, mlat_c});
      off_lon2 <= (side1.kneg ^ side1.sdlat) ? -$signed({1'b0, mlon_c}) : $signed({1'b0, mlon_c});
      side2    <= side1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      flat3 <= WIDE_W'(side2.plat) + off_lat2;
      flon3 <= WIDE_W'(side2.plon) - off_lon2;
      side3 <= side2;
    end
  end

  always_comb begin
    on_c = (WIDE_W'(side3.lat_lo) <= flat3) && (flat3 <= WIDE_W'(side3.lat_hi)) &&
           (WIDE_W'(side3.lon_lo) <= flon3) && (flon3 <= WIDE_W'(side3.lon_hi));
    clat_c = (flat3 > SMAX) || (flat3 < SMIN);
    clon_c = (flon3 > SMAX) || (flon3 < SMIN);
    slat_c = (flat3 > SMAX) ? OUT_W'(SMAX) : (flat3 < SMIN) ? OUT_W'(SMIN) : OUT_W'(flat3);
    slon_c = (flon3 > SMAX) ? OUT_W'(SMAX) : (flon3 < SMIN) ? OUT_W'(SMIN) : OUT_W'(flon3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      out_item.foot_lat   <= side3.degen ? '0 : slat_c;
      out_item.foot_lon   <= side3.degen ? '0 : slon_c;
      out_item.on_segment <= !side3.degen && on_c;
      out_item.degenerate <= side3.degen;
      out_item.clipped    <= !side3.degen && (clat_c || clon_c);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ptsp_out.sv
// Output register with a one-entry skid buffer; stalls the pipeline when the skid fills.
`default_nettype none
module ptsp_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ptsp_pkg::res_t in_item,
  output logic           advance,
  output logic           out_valid,
  input  logic           out_ready,
  output ptsp_pkg::res_t out_item
);
  import ptsp_pkg::*;

  logic skid_valid;
  res_t skid;

  assign advance = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_valid && !skid_valid) begin
        skid       <= in_item;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_item   <= skid;
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_item  <= in_item;
      out_valid <= in_valid;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ptsp_check.sv
// Port-level checker for the projection block, bound to the top level.
`default_nettype none
module ptsp_check (
  input wire                              clk,
  input wire                              rst,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire signed [ptsp_pkg::OUT_W-1:0] foot_lat,
  input wire signed [ptsp_pkg::OUT_W-1:0] foot_lon,
  input wire                              on_segment,
  input wire                              degenerate,
  input wire                              clipped
);
  import ptsp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(foot_lat) && $stable(foot_lon))
    else $error("result changed while stalled");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> foot_lat == '0 && foot_lon == '0 && !on_segment && !clipped)
    else $error("degenerate result not zeroed");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      foot_lat == {1'b0, {(OUT_W-1){1'b1}}} || foot_lat == {1'b1, {(OUT_W-1){1'b0}}} ||
      foot_lon == {1'b0, {(OUT_W-1){1'b1}}} || foot_lon == {1'b1, {(OUT_W-1){1'b0}}})
    else $error("clipped without a saturated coordinate");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind point_to_segment_projection ptsp_check u_check (.*);
`default_nettype wire
